/* rtl/lob_pkg.sv */
// Shared types, widths and codes of the order book core.
`default_nettype none
package lob_pkg;
  localparam int PRICE_W = 10;
  localparam int REF_W   = 12;
  localparam int QTY_W   = 32;
  localparam int CNT_W   = 13;
  localparam int LVL_AW  = PRICE_W + 1;
  localparam int PRICE_LEVELS = 1 << PRICE_W;
  localparam int ORDER_SLOTS  = 1 << REF_W;
  localparam int LEVEL_SLOTS  = 1 << LVL_AW;
  localparam logic [PRICE_W-1:0] PRICE_MIN = '0;
  localparam logic [PRICE_W-1:0] PRICE_MAX = '1;

  localparam logic [1:0] CMD_ADD    = 2'd0;
  localparam logic [1:0] CMD_CANCEL = 2'd1;
  localparam logic [1:0] CMD_TRADE  = 2'd2;

  localparam logic SIDE_BID = 1'b0;
  localparam logic SIDE_ASK = 1'b1;

  localparam logic [1:0] STAT_OK      = 2'd0;
  localparam logic [1:0] STAT_UNKNOWN = 2'd1;
  localparam logic [1:0] STAT_BUSY    = 2'd2;

  typedef struct packed {
    logic               valid;
    logic               side;
    logic [PRICE_W-1:0] price;
    logic [QTY_W-1:0]   qty;
  } ord_entry_t;

  typedef struct packed {
    logic [QTY_W-1:0] qty;
    logic [CNT_W-1:0] cnt;
  } level_t;
endpackage
`default_nettype wire

/* rtl/limit_order_book_levels_core.sv */
// Two-sided limit order book with per-level aggregation and best-price tracking.
`default_nettype none
// The core takes one message per transaction (add, cancel, trade) and returns one
// result per message with the best bid, best ask, side-empty flags and a status.
// Orders live in a 4096-entry order memory, level totals in a 2048-entry level
// memory (side and price); both are synchronous RAMs with registered reads and
// one read port and one write port each. States per message after the accept:
// add E1, LVL_ADD, FIN; cancel E1, LVL_TAKE, FIN; trade E1, E2, WA, LVL_TAKE,
// ASK, LVL_TAKE, FIN; rejected or unused-command messages E1, FIN (E1, E2, FIN
// for a trade whose ask reference is rejected); the result turns valid as the
// core goes back to idle. When a side's best level empties, a rescan in SCAN
// walks the level memory one level per cycle (a trade may rescan both sides).
// The next message is taken while a result still waits at the output register.
// After reset a clearing pass zeroes every entry of both memories; no message is
// accepted during it.
module limit_order_book_levels_core (
  input  wire         clk,
  input  wire         rst,
  input  wire         s_tvalid,
  output logic        s_tready,
  // side[0], order_ref[12:1], ask_ref[24:13], price_tick[34:25], quantity[66:35]
  input  wire  [71:0] s_tdata,
  // command[1:0]
  input  wire  [1:0]  s_tuser,
  output logic        m_tvalid,
  input  wire         m_tready,
  // best_bid[9:0], best_ask[19:10], bid_side_empty[20], ask_side_empty[21]
  output logic [23:0] m_tdata,
  // status[1:0]
  output logic [1:0]  m_tuser
);
  localparam int PW = lob_pkg::PRICE_W;
  localparam int RW = lob_pkg::REF_W;
  localparam int QW = lob_pkg::QTY_W;
  localparam int CW = lob_pkg::CNT_W;
  localparam int AW = lob_pkg::LVL_AW;

  typedef enum logic [3:0] {
    ST_CLEAR, ST_IDLE, ST_E1, ST_E2, ST_WA, ST_ASK, ST_LVL_ADD, ST_LVL_TAKE,
    ST_SCAN, ST_FIN
  } state_t;

  state_t state;

  // input unpacking
  logic          in_side;
  logic [RW-1:0] in_ref, in_aref;
  logic [PW-1:0] in_price;
  logic [QW-1:0] in_qty;
  assign in_side  = s_tdata[0];
  assign in_ref   = s_tdata[RW:1];
  assign in_aref  = s_tdata[2*RW:RW+1];
  assign in_price = s_tdata[2*RW+PW:2*RW+1];
  assign in_qty   = s_tdata[2*RW+PW+QW:2*RW+PW+1];

  // latched message
  logic [1:0]    cmd;
  logic          side;
  logic [RW-1:0] oref, aref;
  logic [PW-1:0] price;
  logic [QW-1:0] qty;

  lob_pkg::ord_entry_t b_ent, a_ent;
  logic [QW-1:0] tq;
  logic          a_drop, ask_pend;
  logic          tk_side, tk_drop;
  logic [PW-1:0] tk_price, scan_idx;
  logic [QW-1:0] tk_qty;
  logic [PW-1:0] best_bid, best_ask;
  logic [CW-1:0] bid_total, ask_total;
  logic [1:0]    status;
  logic [RW-1:0] clr_idx;

  // memories
  lob_pkg::ord_entry_t ord_mem [lob_pkg::ORDER_SLOTS];
  lob_pkg::level_t     lvl_mem [lob_pkg::LEVEL_SLOTS];
  lob_pkg::ord_entry_t ord_rd, ord_wdata;
  lob_pkg::level_t     lvl_rd, lvl_wdata;
  logic [RW-1:0] ord_raddr, ord_waddr;
  logic [AW-1:0] lvl_raddr, lvl_waddr;
  logic          ord_we, lvl_we;

  always_ff @(posedge clk) begin
    if (ord_we) begin
      ord_mem[ord_waddr] <= ord_wdata;
    end
    ord_rd <= ord_mem[ord_raddr];
  end

  always_ff @(posedge clk) begin
    if (lvl_we) begin
      lvl_mem[lvl_waddr] <= lvl_wdata;
    end
    lvl_rd <= lvl_mem[lvl_raddr];
  end

  // trade amount and remainders
  logic [QW-1:0] q1, qt, b_new, a_new;
  assign q1    = (qty > b_ent.qty) ? b_ent.qty : qty;
  assign qt    = (q1 > ord_rd.qty) ? ord_rd.qty : q1;
  assign b_new = b_ent.qty - qt;
  assign a_new = a_ent.qty - tq;

  logic cancel_ok, bid_ok, ask_ok;
  assign cancel_ok = ord_rd.valid && (ord_rd.side == side);
  assign bid_ok    = ord_rd.valid && (ord_rd.side == lob_pkg::SIDE_BID);
  assign ask_ok    = ord_rd.valid && (ord_rd.side == lob_pkg::SIDE_ASK);

  // level arithmetic
  logic [QW:0]   add_sum;
  logic [QW-1:0] add_qty, take_qty;
  logic [CW-1:0] take_cnt, take_tot, take_tot_next;
  logic [PW-1:0] take_best, take_bound, tk_step, scan_step, scan_bound;
  assign add_sum  = {1'b0, lvl_rd.qty} + {1'b0, qty};
  assign add_qty  = add_sum[QW] ? '1 : add_sum[QW-1:0];
  assign take_qty = (lvl_rd.qty >= tk_qty) ? lvl_rd.qty - tk_qty : '0;
  assign take_cnt = (tk_drop && lvl_rd.cnt != '0) ? lvl_rd.cnt - 1'b1 : lvl_rd.cnt;
  assign take_tot = (tk_side == lob_pkg::SIDE_ASK) ? ask_total : bid_total;
  assign take_tot_next = (tk_drop && take_tot != '0) ? take_tot - 1'b1 : take_tot;
  assign take_best  = (tk_side == lob_pkg::SIDE_ASK) ? best_ask : best_bid;
  assign take_bound = (tk_side == lob_pkg::SIDE_ASK) ? lob_pkg::PRICE_MAX
                                                     : lob_pkg::PRICE_MIN;
  // bids scan downward, asks upward
  assign tk_step    = (tk_side == lob_pkg::SIDE_ASK) ? tk_price + 1'b1 : tk_price - 1'b1;
  assign scan_step  = (tk_side == lob_pkg::SIDE_ASK) ? scan_idx + 1'b1 : scan_idx - 1'b1;
  assign scan_bound = take_bound;

  always_comb begin
    ord_raddr = (state == ST_IDLE) ? in_ref : aref;
    ord_we    = 1'b0;
    ord_waddr = oref;
    ord_wdata = '0;
    lvl_we    = 1'b0;
    lvl_waddr = {tk_side, tk_price};
    lvl_wdata = '0;
    lvl_raddr = {tk_side, tk_price};
    case (state)
      ST_CLEAR: begin
        ord_we    = 1'b1;
        ord_waddr = clr_idx;
        lvl_we    = 1'b1;
        lvl_waddr = clr_idx[AW-1:0];
      end
      ST_E1: begin
        if (cmd == lob_pkg::CMD_ADD) begin
          lvl_raddr = {side, price};
          ord_we    = !ord_rd.valid;
          ord_wdata = '{valid: 1'b1, side: side, price: price, qty: qty};
        end else begin
          lvl_raddr = {side, ord_rd.price};
          ord_we    = (cmd == lob_pkg::CMD_CANCEL) && cancel_ok;
          ord_wdata = '{valid: 1'b0, side: ord_rd.side, price: ord_rd.price, qty: '0};
        end
      end
      ST_E2: begin
        ord_we    = ask_ok;
        ord_wdata = '{valid: (b_new != '0), side: lob_pkg::SIDE_BID,
                      price: b_ent.price, qty: b_new};
      end
      ST_WA: begin
        ord_we    = 1'b1;
        ord_waddr = aref;
        ord_wdata = '{valid: (a_new != '0), side: lob_pkg::SIDE_ASK,
                      price: a_ent.price, qty: a_new};
      end
      ST_ASK: begin
        lvl_raddr = {lob_pkg::SIDE_ASK, a_ent.price};
      end
      ST_LVL_ADD: begin
        lvl_we    = 1'b1;
        lvl_waddr = {side, price};
        lvl_wdata = '{qty: add_qty, cnt: lvl_rd.cnt + 1'b1};
      end
      ST_LVL_TAKE: begin
        lvl_we    = 1'b1;
        lvl_wdata = '{qty: take_qty, cnt: take_cnt};
        lvl_raddr = {tk_side, tk_step};
      end
      ST_SCAN: begin
        lvl_raddr = {tk_side, scan_step};
      end
      default: begin
      end
    endcase
  end

  // controller
  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= ST_CLEAR;
      clr_idx   <= '0;
      m_tvalid  <= 1'b0;
      best_bid  <= lob_pkg::PRICE_MIN;
      best_ask  <= lob_pkg::PRICE_MAX;
      bid_total <= '0;
      ask_total <= '0;
      ask_pend  <= 1'b0;
    end else begin
      // a result leaving while the next one is loaded is handled in ST_FIN
      if (m_tvalid && m_tready && state != ST_FIN) begin
        m_tvalid <= 1'b0;
      end
      case (state)
        ST_CLEAR: begin
          clr_idx <= clr_idx + 1'b1;
          if (clr_idx == '1) begin
            state <= ST_IDLE;
          end
        end
        ST_IDLE: begin
          if (s_tvalid) begin
            cmd    <= s_tuser;
            side   <= in_side;
            oref   <= in_ref;
            aref   <= in_aref;
            price  <= in_price;
            qty    <= in_qty;
            status <= lob_pkg::STAT_OK;
            state  <= ST_E1;
          end
        end
        ST_E1: begin
          case (cmd)
            lob_pkg::CMD_ADD: begin
              if (ord_rd.valid) begin
                status <= lob_pkg::STAT_BUSY;
                state  <= ST_FIN;
              end else begin
                state <= ST_LVL_ADD;
              end
            end
            lob_pkg::CMD_CANCEL: begin
              tk_side  <= side;
              tk_price <= ord_rd.price;
              tk_qty   <= ord_rd.qty;
              tk_drop  <= 1'b1;
              if (cancel_ok) begin
                state <= ST_LVL_TAKE;
              end else begin
                status <= lob_pkg::STAT_UNKNOWN;
                state  <= ST_FIN;
              end
            end
            lob_pkg::CMD_TRADE: begin
              b_ent <= ord_rd;
              if (bid_ok) begin
                state <= ST_E2;
              end else begin
                status <= lob_pkg::STAT_UNKNOWN;
                state  <= ST_FIN;
              end
            end
            default: state <= ST_FIN;
          endcase
        end
        ST_E2: begin
          a_ent    <= ord_rd;
          tq       <= qt;
          tk_side  <= lob_pkg::SIDE_BID;
          tk_price <= b_ent.price;
          tk_qty   <= qt;
          tk_drop  <= (b_new == '0);
          if (ask_ok) begin
            state <= ST_WA;
          end else begin
            status <= lob_pkg::STAT_UNKNOWN;
            state  <= ST_FIN;
          end
        end
        ST_WA: begin
          a_drop   <= (a_new == '0);
          ask_pend <= 1'b1;
          state    <= ST_LVL_TAKE;
        end
        ST_ASK: begin
          ask_pend <= 1'b0;
          tk_side  <= lob_pkg::SIDE_ASK;
          tk_price <= a_ent.price;
          tk_qty   <= tq;
          tk_drop  <= a_drop;
          state    <= ST_LVL_TAKE;
        end
        ST_LVL_ADD: begin
          if (side == lob_pkg::SIDE_BID) begin
            if (bid_total == '0 || price > best_bid) best_bid <= price;
            bid_total <= bid_total + 1'b1;
          end else begin
            if (ask_total == '0 || price < best_ask) best_ask <= price;
            ask_total <= ask_total + 1'b1;
          end
          state <= ST_FIN;
        end
        ST_LVL_TAKE: begin
          if (tk_side == lob_pkg::SIDE_ASK) ask_total <= take_tot_next;
          else bid_total <= take_tot_next;
          scan_idx <= tk_step;
          if (tk_drop && take_tot_next == '0) begin
            if (tk_side == lob_pkg::SIDE_ASK) best_ask <= lob_pkg::PRICE_MAX;
            else best_bid <= lob_pkg::PRICE_MIN;
          end
          // best level just emptied: walk to the next occupied one
          if (tk_drop && take_tot_next != '0 && take_cnt == '0 &&
              tk_price == take_best && tk_price != take_bound) begin
            state <= ST_SCAN;
          end else begin
            state <= ask_pend ? ST_ASK : ST_FIN;
          end
        end
        ST_SCAN: begin
          // lvl_rd holds the count at scan_idx
          if (lvl_rd.cnt != '0 || scan_idx == scan_bound) begin
            if (tk_side == lob_pkg::SIDE_ASK) best_ask <= scan_idx;
            else best_bid <= scan_idx;
            state <= ask_pend ? ST_ASK : ST_FIN;
          end else begin
            scan_idx <= scan_step;
          end
        end
        ST_FIN: begin
          if (!m_tvalid || m_tready) begin
            m_tvalid <= 1'b1;
            m_tdata  <= {2'b00, (ask_total == '0), (bid_total == '0), best_ask, best_bid};
            m_tuser  <= status;
            state    <= ST_IDLE;
          end
        end
        default: state <= ST_IDLE;
      endcase
    end
  end

  assign s_tready = (state == ST_IDLE);

  // checks
  a_bid_empty_best: assert property (@(posedge clk) disable iff (rst)
    bid_total == '0 |-> best_bid == lob_pkg::PRICE_MIN)
    else $error("bid side empty but best bid not reset");
  a_ask_empty_best: assert property (@(posedge clk) disable iff (rst)
    ask_total == '0 |-> best_ask == lob_pkg::PRICE_MAX)
    else $error("ask side empty but best ask not reset");
  a_accept_lookup: assert property (@(posedge clk) disable iff (rst)
    s_tvalid && s_tready |=> state == ST_E1)
    else $error("accepted transaction did not start order lookup");
  a_no_accept_clear: assert property (@(posedge clk) disable iff (rst)
    state == ST_CLEAR |-> !s_tready)
    else $error("transaction accepted during clearing pass");
endmodule
`default_nettype wire

/* verif/lob_checker.sv */
// Order book checker: predicts each result from accepted messages and compares.
module lob_checker (
  input  wire         clk,
  input  wire         rst,
  input  wire         s_tvalid,
  input  wire         s_tready,
  input  wire  [71:0] s_tdata,
  input  wire  [1:0]  s_tuser,
  input  wire         m_tvalid,
  input  wire         m_tready,
  input  wire  [23:0] m_tdata,
  input  wire  [1:0]  m_tuser,
  output int          fail_count,
  output int          pending
);

  typedef struct {
    logic [lob_pkg::PRICE_W-1:0] best_bid;
    logic [lob_pkg::PRICE_W-1:0] best_ask;
    logic                        bid_empty;
    logic                        ask_empty;
    logic [1:0]                  status;
  } book_view_t;

  // Model copy of the book
  logic                        ord_valid [lob_pkg::ORDER_SLOTS];
  logic                        ord_side  [lob_pkg::ORDER_SLOTS];
  logic [lob_pkg::PRICE_W-1:0] ord_price [lob_pkg::ORDER_SLOTS];
  logic [lob_pkg::QTY_W-1:0]   ord_qty   [lob_pkg::ORDER_SLOTS];
  logic [lob_pkg::QTY_W-1:0]   lvl_qty   [2][lob_pkg::PRICE_LEVELS];
  int                          lvl_cnt   [2][lob_pkg::PRICE_LEVELS];
  logic [lob_pkg::PRICE_W-1:0] top_bid, top_ask;
  int                          bid_total, ask_total;

  book_view_t views_due[$];

  assign pending = views_due.size();

  task automatic clear_book();
    for (int i = 0; i < lob_pkg::ORDER_SLOTS; i++) begin
      ord_valid[i] = 1'b0;
      ord_side[i]  = lob_pkg::SIDE_BID;
      ord_price[i] = '0;
      ord_qty[i]   = '0;
    end
    for (int s = 0; s < 2; s++)
      for (int p = 0; p < lob_pkg::PRICE_LEVELS; p++) begin
        lvl_qty[s][p] = '0;
        lvl_cnt[s][p] = 0;
      end
    top_bid   = lob_pkg::PRICE_MIN;
    top_ask   = lob_pkg::PRICE_MAX;
    bid_total = 0;
    ask_total = 0;
  endtask

  function automatic void walk_bid();
    if (bid_total == 0) begin
      top_bid = lob_pkg::PRICE_MIN;
    end else begin
      while (top_bid > lob_pkg::PRICE_MIN && lvl_cnt[lob_pkg::SIDE_BID][top_bid] == 0)
        top_bid--;
    end
  endfunction

  function automatic void walk_ask();
    if (ask_total == 0) begin
      top_ask = lob_pkg::PRICE_MAX;
    end else begin
      while (top_ask < lob_pkg::PRICE_MAX && lvl_cnt[lob_pkg::SIDE_ASK][top_ask] == 0)
        top_ask++;
    end
  endfunction

  // Remove q from a level; an order leaves it when drop is set
  function automatic void drain_level(logic s, logic [lob_pkg::PRICE_W-1:0] p,
                                      logic [lob_pkg::QTY_W-1:0] q, bit drop);
    lvl_qty[s][p] = (lvl_qty[s][p] >= q) ? lvl_qty[s][p] - q : '0;
    if (drop) begin
      if (lvl_cnt[s][p] > 0) lvl_cnt[s][p]--;
      if (s == lob_pkg::SIDE_BID) begin
        if (bid_total > 0) bid_total--;
        if ((lvl_cnt[s][p] == 0 && p == top_bid) || bid_total == 0) walk_bid();
      end else begin
        if (ask_total > 0) ask_total--;
        if ((lvl_cnt[s][p] == 0 && p == top_ask) || ask_total == 0) walk_ask();
      end
    end
  endfunction

  function automatic logic [1:0] book_add(logic s, logic [lob_pkg::REF_W-1:0] r,
                                          logic [lob_pkg::PRICE_W-1:0] p,
                                          logic [lob_pkg::QTY_W-1:0] q);
    if (ord_valid[r]) return lob_pkg::STAT_BUSY;
    ord_valid[r] = 1'b1;
    ord_side[r]  = s;
    ord_price[r] = p;
    ord_qty[r]   = q;
    lvl_qty[s][p] = (lvl_qty[s][p] > ~q) ? '1 : lvl_qty[s][p] + q;
    lvl_cnt[s][p]++;
    if (s == lob_pkg::SIDE_BID) begin
      if (bid_total == 0 || p > top_bid) top_bid = p;
      bid_total++;
    end else begin
      if (ask_total == 0 || p < top_ask) top_ask = p;
      ask_total++;
    end
    return lob_pkg::STAT_OK;
  endfunction

  function automatic logic [1:0] book_cancel(logic s, logic [lob_pkg::REF_W-1:0] r);
    if (!ord_valid[r] || ord_side[r] != s) return lob_pkg::STAT_UNKNOWN;
    ord_valid[r] = 1'b0;
    drain_level(s, ord_price[r], ord_qty[r], 1'b1);
    ord_qty[r] = '0;
    return lob_pkg::STAT_OK;
  endfunction

  function automatic logic [1:0] book_trade(logic [lob_pkg::REF_W-1:0] br,
                                            logic [lob_pkg::REF_W-1:0] ar,
                                            logic [lob_pkg::QTY_W-1:0] q);
    logic [lob_pkg::QTY_W-1:0] fill;
    fill = q;
    if (!ord_valid[br] || ord_side[br] != lob_pkg::SIDE_BID) return lob_pkg::STAT_UNKNOWN;
    if (!ord_valid[ar] || ord_side[ar] != lob_pkg::SIDE_ASK) return lob_pkg::STAT_UNKNOWN;
    if (fill > ord_qty[br]) fill = ord_qty[br];
    if (fill > ord_qty[ar]) fill = ord_qty[ar];
    ord_qty[br] -= fill;
    ord_qty[ar] -= fill;
    if (ord_qty[br] == '0) ord_valid[br] = 1'b0;
    if (ord_qty[ar] == '0) ord_valid[ar] = 1'b0;
    drain_level(lob_pkg::SIDE_BID, ord_price[br], fill, !ord_valid[br]);
    drain_level(lob_pkg::SIDE_ASK, ord_price[ar], fill, !ord_valid[ar]);
    return lob_pkg::STAT_OK;
  endfunction

  function automatic book_view_t apply_message(logic [1:0] cmd, logic [71:0] d);
    book_view_t v;
    v.status = lob_pkg::STAT_OK;
    case (cmd)
      lob_pkg::CMD_ADD:    v.status = book_add(d[0], d[12:1], d[34:25], d[66:35]);
      lob_pkg::CMD_CANCEL: v.status = book_cancel(d[0], d[12:1]);
      lob_pkg::CMD_TRADE:  v.status = book_trade(d[12:1], d[24:13], d[66:35]);
      default:             v.status = lob_pkg::STAT_OK;  // unused code is ignored
    endcase
    v.best_bid  = top_bid;
    v.best_ask  = top_ask;
    v.bid_empty = (bid_total == 0);
    v.ask_empty = (ask_total == 0);
    return v;
  endfunction

  task automatic check_field(string name, int unsigned exp_v, int unsigned act_v);
    if (exp_v != act_v) begin
      $error("%s mismatch: expected %0d, actual %0d", name, exp_v, act_v);
      fail_count++;
    end
  endtask

  always @(posedge clk) begin
    book_view_t e;
    if (rst) begin
      clear_book();
      views_due.delete();
      fail_count = 0;
    end else begin
      if (m_tvalid && m_tready) begin
        if (views_due.size() == 0) begin
          $error("result transaction with no message outstanding: data %h", m_tdata);
          fail_count++;
        end else begin
          e = views_due.pop_front();
          check_field("best_bid", e.best_bid, m_tdata[9:0]);
          check_field("best_ask", e.best_ask, m_tdata[19:10]);
          check_field("bid_side_empty", e.bid_empty, m_tdata[20]);
          check_field("ask_side_empty", e.ask_empty, m_tdata[21]);
          check_field("status", e.status, m_tuser);
        end
      end
      if (s_tvalid && s_tready)
        views_due.insert(views_due.size(), apply_message(s_tuser, s_tdata));
    end
  end

endmodule

/* verif/tb_top.sv */
// Testbench top: drives order book messages and random backpressure, gives the verdict.
module tb_top;

  localparam logic [1:0] CMD_UNUSED = 2'd3;
  localparam int         RAND_ITEMS = 750;
  localparam longint     CYCLE_LIMIT = 10_000_000;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        s_tvalid = 1'b0;
  logic        s_tready;
  logic [71:0] s_tdata = '0;
  logic [1:0]  s_tuser = '0;
  logic        m_tvalid;
  logic        m_tready = 1'b0;
  logic [23:0] m_tdata;
  logic [1:0]  m_tuser;
  int          fail_count;
  int          pending;
  int          rx_hold = 0;  // one-shot long stall for the result side
  longint      cycles = 0;
  bit          tx_eager = 1'b0;

  always #10 clk = ~clk;

  limit_order_book_levels_core u_top (
    .clk(clk), .rst(rst),
    .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata), .s_tuser(s_tuser),
    .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata), .m_tuser(m_tuser)
  );

  lob_checker u_chk (
    .clk(clk), .rst(rst),
    .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata), .s_tuser(s_tuser),
    .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata), .m_tuser(m_tuser),
    .fail_count(fail_count), .pending(pending)
  );

  // Watchdog
  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles == CYCLE_LIMIT) begin
      $display("simulation failed");
      $finish;
    end
  end

  // Result side: random stall per transaction, stretches with none, one long hold
  initial begin
    int gap;
    int n_rx;
    n_rx = 0;
    @(negedge rst);
    forever begin
      gap = ((n_rx / 40) % 3 == 1) ? 0 : $urandom_range(0, 12);
      if (rx_hold > 0) begin
        gap = rx_hold;
        rx_hold = 0;
      end
      if (gap > 0) begin
        m_tready <= 1'b0;
        repeat (gap) @(posedge clk);
      end
      m_tready <= 1'b1;
      do @(posedge clk); while (!m_tvalid);
      n_rx++;
    end
  end

  // One message transaction; valid stays high across back-to-back messages
  task automatic send_msg(logic [1:0] cmd, logic side, logic [lob_pkg::REF_W-1:0] oref,
                          logic [lob_pkg::REF_W-1:0] aref,
                          logic [lob_pkg::PRICE_W-1:0] tick,
                          logic [lob_pkg::QTY_W-1:0] qty);
    int gap;
    gap = tx_eager ? 0 : $urandom_range(0, 12);
    if (gap > 0) begin
      s_tvalid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    s_tvalid <= 1'b1;
    s_tuser  <= cmd;
    s_tdata  <= {5'b0, qty, tick, aref, oref, side};
    do @(posedge clk); while (!s_tready);
  endtask

  task automatic drain_results();
    s_tvalid <= 1'b0;
    do @(posedge clk); while (pending != 0);
  endtask

  initial begin
    int kind;
    logic side;
    logic [lob_pkg::REF_W-1:0] oref, aref;
    logic [lob_pkg::PRICE_W-1:0] tick;
    logic [lob_pkg::QTY_W-1:0] qty;

    repeat (4) @(posedge clk);
    rst <= 1'b0;

    // Directed: extremes, busy and unknown references, zero fills, saturation
    send_msg(lob_pkg::CMD_ADD, lob_pkg::SIDE_BID, 12'd0, 12'd0, lob_pkg::PRICE_MIN, 32'd5);
    send_msg(lob_pkg::CMD_ADD, lob_pkg::SIDE_ASK, 12'd4095, 12'd0, lob_pkg::PRICE_MAX,
             32'hFFFF_FFFF);
    send_msg(lob_pkg::CMD_ADD, lob_pkg::SIDE_ASK, 12'd4094, 12'd0, lob_pkg::PRICE_MAX,
             32'hFFFF_FFFF);
    send_msg(lob_pkg::CMD_ADD, lob_pkg::SIDE_BID, 12'd0, 12'd0, 10'd7, 32'd1);  // busy ref
    send_msg(lob_pkg::CMD_ADD, lob_pkg::SIDE_BID, 12'd1, 12'd0, lob_pkg::PRICE_MAX,
             32'd0);  // zero qty
    send_msg(lob_pkg::CMD_ADD, lob_pkg::SIDE_ASK, 12'd2, 12'd0, lob_pkg::PRICE_MIN, 32'd0);
    send_msg(lob_pkg::CMD_CANCEL, lob_pkg::SIDE_ASK, 12'd0, 12'd0, '0, '0);   // wrong side
    send_msg(lob_pkg::CMD_CANCEL, lob_pkg::SIDE_BID, 12'd77, 12'd0, '0, '0);  // unknown
    send_msg(lob_pkg::CMD_TRADE, lob_pkg::SIDE_BID, 12'd4095, 12'd2, '0, 32'd3);  // bid is ask
    send_msg(lob_pkg::CMD_TRADE, lob_pkg::SIDE_BID, 12'd0, 12'd0, '0, 32'd3);     // ask is bid
    send_msg(lob_pkg::CMD_TRADE, lob_pkg::SIDE_BID, 12'd0, 12'd99, '0, 32'd3);  // ask unknown
    send_msg(lob_pkg::CMD_TRADE, lob_pkg::SIDE_BID, 12'd1, 12'd2, 10'h3FF, 32'd0);  // frees both
    send_msg(lob_pkg::CMD_TRADE, lob_pkg::SIDE_ASK, 12'd0, 12'd4095, 10'h155, 32'hFFFF_FFFF);
    send_msg(CMD_UNUSED, lob_pkg::SIDE_ASK, 12'hFFF, 12'hFFF, 10'h3FF, 32'hFFFF_FFFF);
    send_msg(lob_pkg::CMD_CANCEL, lob_pkg::SIDE_ASK, 12'd4095, 12'd0, '0, '0);
    send_msg(lob_pkg::CMD_CANCEL, lob_pkg::SIDE_ASK, 12'd4094, 12'd0, '0, '0);  // ask empties
    send_msg(lob_pkg::CMD_ADD, lob_pkg::SIDE_BID, 12'd5, 12'd0, 10'd600, 32'd9);
    send_msg(lob_pkg::CMD_CANCEL, lob_pkg::SIDE_BID, 12'd5, 12'd0, '0, '0);  // bid empties
    send_msg(lob_pkg::CMD_ADD, lob_pkg::SIDE_ASK, 12'd6, 12'd0, 10'd400, 32'd9);
    send_msg(lob_pkg::CMD_ADD, lob_pkg::SIDE_ASK, 12'd8, 12'd0, 10'd900, 32'd9);
    send_msg(lob_pkg::CMD_CANCEL, lob_pkg::SIDE_ASK, 12'd6, 12'd0, '0, '0);  // rescan up
    send_msg(lob_pkg::CMD_CANCEL, lob_pkg::SIDE_BID, 12'd0, 12'd0, '0, '0);  // unknown
    drain_results();

    // Random: mostly well-formed traffic over a small reference pool,
    // even references bid and odd ones ask, prices clustered near the spread
    for (int i = 0; i < RAND_ITEMS; i++) begin
      tx_eager = ((i / 50) % 4 == 2);
      if (i == 300) rx_hold = 400;
      if (i == 500) drain_results();
      kind = $urandom_range(0, 99);
      side = 1'($urandom_range(0, 1));
      oref = {6'd0, 5'($urandom_range(0, 31)), side};
      aref = {6'd0, 5'($urandom_range(0, 31)), 1'b1};
      qty  = ($urandom_range(0, 9) == 0) ? $urandom() : $urandom_range(0, 120);
      if ($urandom_range(0, 49) == 0)
        tick = side ? 10'($urandom_range(900, 1023)) : 10'($urandom_range(0, 120));
      else
        tick = side ? 10'($urandom_range(512, 543)) : 10'($urandom_range(480, 511));
      if (kind < 45)
        send_msg(lob_pkg::CMD_ADD, side, oref, aref, tick, qty);
      else if (kind < 70)
        send_msg(lob_pkg::CMD_CANCEL, side, oref, aref, tick, qty);
      else if (kind < 95)
        send_msg(lob_pkg::CMD_TRADE, side, {oref[lob_pkg::REF_W-1:1], lob_pkg::SIDE_BID},
                 aref, tick, qty);
      else
        send_msg(2'($urandom_range(0, 3)), 1'($urandom_range(0, 1)), 12'($urandom()),
                 12'($urandom()), 10'($urandom()), $urandom());
    end

    drain_results();
    repeat (1100) @(posedge clk);
    if (fail_count == 0 && pending == 0)
      $display("simulation ok");
    else
      $display("simulation failed");
    $finish;
  end

endmodule
